// ===== design/wse_pkg.sv =====
// shared types and constants for the wheel encoder speed estimator
package wse_pkg;

   localparam int NUM_BITS   = 32;
   localparam int SPEED_BITS = 16;
   localparam int DIST_BITS  = 32;
   localparam int DATA_BITS  = 32;
   localparam int CSR_BITS   = 2;

   localparam logic [15:0] STEP_DISTANCE_RST   = 16'd1;
   localparam logic [31:0] SPEED_NUMERATOR_RST = 32'd65536;
   localparam logic [14:0] SPEED_LIMIT_RST     = 15'd21299;
   localparam logic [8:0]  FILTER_WEIGHT_RST   = 9'd205;
   localparam logic [8:0]  FILTER_WEIGHT_MAX   = 9'd256;

   localparam logic [31:0] SPEED_POS_MAX = 32'd32767;
   localparam logic [31:0] SPEED_NEG_MAG = 32'd32768;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_FILT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_STEP_DISTANCE   = 2'd0,
      CSR_SPEED_NUMERATOR = 2'd1,
      CSR_SPEED_LIMIT     = 2'd2,
      CSR_FILTER_WEIGHT   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_FWD  = 2'd1,
      MARK_REV  = 2'd2
   } mark_type;

   localparam logic OP_CAPTURE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

endpackage

// ===== design/wheel_encoder_speed_estimator_top.sv =====
// two-wheel encoder speed and distance estimator with a shared radix-2 divider
// capture transaction: wheel state updates on acceptance, then the completion state writes the result
// tick transaction: the 32-step restoring divider runs once per wheel,
// followed by one multiply and one filter step per wheel
// one transaction at a time; a new result waits in the completion state, stall high, until the old one is taken
// reset is synchronous: registers return to defaults, wheel state clears at once
module wheel_encoder_speed_estimator_top #(
   parameter int CAPTURE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic                              req_wheel,
   input  logic [15:0]                       req_capture_value,
   input  logic                              req_forward,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_left_speed,
   output logic signed [15:0]                rsp_right_speed,
   output logic signed [15:0]                rsp_mean_speed,
   output logic signed [31:0]                rsp_mean_distance,
   input  logic                              csr_wr_en,
   input  logic [wse_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [wse_pkg::DATA_BITS-1:0]     csr_wdata
);
   import wse_pkg::*;

   localparam int PER_W = CAPTURE_BITS + 1;
   localparam int REM_W = CAPTURE_BITS + 2;
   localparam int CNT_W = $clog2(NUM_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BITS - 1);
   localparam logic [PER_W-1:0] PER_FULL = {1'b1, {CAPTURE_BITS{1'b0}}};

   // configuration
   logic [15:0] step_distance_ff, step_distance_in;
   logic [31:0] speed_numerator_ff, speed_numerator_in;
   logic [14:0] speed_limit_ff, speed_limit_in;
   logic [8:0]  filter_weight_ff, filter_weight_in;

   // wheel state
   logic [CAPTURE_BITS-1:0] last_capture_ff [2];
   logic [CAPTURE_BITS-1:0] last_capture_in [2];
   logic [PER_W-1:0]        edge_period_ff [2];
   logic [PER_W-1:0]        edge_period_in [2];
   mark_type                moved_mark_ff [2];
   mark_type                moved_mark_in [2];
   logic [DIST_BITS-1:0]    wheel_distance_ff [2];
   logic [DIST_BITS-1:0]    wheel_distance_in [2];
   logic [SPEED_BITS-1:0]   wheel_speed_ff [2];
   logic [SPEED_BITS-1:0]   wheel_speed_in [2];

   // sequencer and shared datapath
   state_type               state_ff, state_in;
   logic                    wheel_ff, wheel_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]     dq_ff, dq_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [PER_W-1:0]        div_ff, div_in;
   logic [SPEED_BITS-1:0]   raw_ff, raw_in;
   logic signed [26:0]      prod_ff, prod_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_left_ff, rsp_left_in;
   logic [15:0]             rsp_right_ff, rsp_right_in;
   logic [15:0]             rsp_mean_ff, rsp_mean_in;
   logic [31:0]             rsp_dist_ff, rsp_dist_in;

   logic                    req_accept;
   logic [31:0]             cap_wide;
   logic [CAPTURE_BITS-1:0] cap_val;
   logic [CAPTURE_BITS-1:0] cap_diff;
   logic [REM_W-1:0]        rem_sh;
   logic [REM_W-1:0]        div_ext;
   logic                    rem_ge;
   logic [SPEED_BITS-1:0]   sat_s;
   logic [16:0]             sat_mag;
   logic [16:0]             neg_q;
   logic [SPEED_BITS-1:0]   last_s;
   logic [SPEED_BITS-1:0]   raw_s;
   logic signed [16:0]      diff_s;
   logic [8:0]              w_eff;
   logic signed [26:0]      filt_sum;
   logic [16:0]             speed_sum;
   logic [32:0]             dist_sum;

   function automatic logic [PER_W-1:0] fix_period(input logic [PER_W-1:0] p);
      fix_period = (p == '0) ? PER_FULL : p;
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   assign cap_wide = {16'b0, req_capture_value};
   assign cap_val  = cap_wide[CAPTURE_BITS-1:0];
   assign cap_diff = cap_val - last_capture_ff[req_wheel];

   assign rem_sh  = {rem_ff[REM_W-2:0], dq_ff[NUM_BITS-1]};
   assign div_ext = {1'b0, div_ff};
   assign rem_ge  = (rem_sh >= div_ext);

   // saturate the quotient and sign it by direction
   assign neg_q  = 17'd0 - dq_ff[16:0];
   assign last_s = wheel_speed_ff[wheel_ff];
   always_comb begin
      sat_s   = '0;
      sat_mag = '0;
      case (moved_mark_ff[wheel_ff])
         MARK_FWD: begin
            if (dq_ff > SPEED_POS_MAX) begin
               sat_s   = SPEED_POS_MAX[15:0];
               sat_mag = SPEED_POS_MAX[16:0];
            end else begin
               sat_s   = dq_ff[15:0];
               sat_mag = dq_ff[16:0];
            end
         end
         MARK_REV: begin
            if (dq_ff > SPEED_NEG_MAG) begin
               sat_s   = 16'h8000;
               sat_mag = SPEED_NEG_MAG[16:0];
            end else begin
               sat_s   = neg_q[15:0];
               sat_mag = dq_ff[16:0];
            end
         end
         default: begin
            sat_s   = '0;
            sat_mag = '0;
         end
      endcase
   end

   assign raw_s    = (sat_mag > {2'b0, speed_limit_ff}) ? last_s : sat_s;
   assign diff_s   = $signed({last_s[15], last_s}) - $signed({raw_s[15], raw_s});
   assign w_eff    = (filter_weight_ff > FILTER_WEIGHT_MAX) ? FILTER_WEIGHT_MAX
                                                            : filter_weight_ff;
   // new = raw + floor((last - raw) * w / 256)
   assign filt_sum = $signed({{11{raw_ff[15]}}, raw_ff}) + (prod_ff >>> 8);

   assign speed_sum = {wheel_speed_ff[0][15], wheel_speed_ff[0]}
                    + {wheel_speed_ff[1][15], wheel_speed_ff[1]};
   assign dist_sum  = {wheel_distance_ff[0][31], wheel_distance_ff[0]}
                    + {wheel_distance_ff[1][31], wheel_distance_ff[1]};

   always_comb begin
      step_distance_in   = step_distance_ff;
      speed_numerator_in = speed_numerator_ff;
      speed_limit_in     = speed_limit_ff;
      filter_weight_in   = filter_weight_ff;
      last_capture_in    = last_capture_ff;
      edge_period_in     = edge_period_ff;
      moved_mark_in      = moved_mark_ff;
      wheel_distance_in  = wheel_distance_ff;
      wheel_speed_in     = wheel_speed_ff;
      state_in           = state_ff;
      wheel_in           = wheel_ff;
      cnt_in             = cnt_ff;
      dq_in              = dq_ff;
      rem_in             = rem_ff;
      div_in             = div_ff;
      raw_in             = raw_ff;
      prod_in            = prod_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_left_in        = rsp_left_ff;
      rsp_right_in       = rsp_right_ff;
      rsp_mean_in        = rsp_mean_ff;
      rsp_dist_in        = rsp_dist_ff;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_DISTANCE:   step_distance_in   = csr_wdata[15:0];
            CSR_SPEED_NUMERATOR: speed_numerator_in = csr_wdata[31:0];
            CSR_SPEED_LIMIT:     speed_limit_in     = csr_wdata[14:0];
            CSR_FILTER_WEIGHT:   filter_weight_in   = csr_wdata[8:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_op == OP_CAPTURE) begin
                  last_capture_in[req_wheel] = cap_val;
                  edge_period_in[req_wheel]  = fix_period({1'b0, cap_diff});
                  if (req_forward) begin
                     moved_mark_in[req_wheel]     = MARK_FWD;
                     wheel_distance_in[req_wheel] = wheel_distance_ff[req_wheel]
                                                  + {16'b0, step_distance_ff};
                  end else begin
                     moved_mark_in[req_wheel]     = MARK_REV;
                     wheel_distance_in[req_wheel] = wheel_distance_ff[req_wheel]
                                                  - {16'b0, step_distance_ff};
                  end
                  state_in = ST_DONE;
               end else begin
                  wheel_in = 1'b0;
                  cnt_in   = '0;
                  dq_in    = speed_numerator_ff;
                  rem_in   = '0;
                  div_in   = fix_period(edge_period_ff[0]);
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? (rem_sh - div_ext) : rem_sh;
            dq_in  = {dq_ff[NUM_BITS-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            raw_in   = raw_s;
            prod_in  = diff_s * $signed({1'b0, w_eff});
            state_in = ST_FILT;
         end
         ST_FILT: begin
            wheel_speed_in[wheel_ff] = filt_sum[15:0];
            moved_mark_in[wheel_ff]  = MARK_NONE;
            if (!wheel_ff) begin
               wheel_in = 1'b1;
               cnt_in   = '0;
               dq_in    = speed_numerator_ff;
               rem_in   = '0;
               div_in   = fix_period(edge_period_ff[1]);
               state_in = ST_DIV;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = wheel_speed_ff[0];
               rsp_right_in = wheel_speed_ff[1];
               rsp_mean_in  = speed_sum[16:1];
               rsp_dist_in  = dist_sum[32:1];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_distance_ff   <= STEP_DISTANCE_RST;
         speed_numerator_ff <= SPEED_NUMERATOR_RST;
         speed_limit_ff     <= SPEED_LIMIT_RST;
         filter_weight_ff   <= FILTER_WEIGHT_RST;
         for (int k = 0; k < 2; k++) begin
            last_capture_ff[k]   <= '0;
            edge_period_ff[k]    <= '0;
            moved_mark_ff[k]     <= MARK_NONE;
            wheel_distance_ff[k] <= '0;
            wheel_speed_ff[k]    <= '0;
         end
         state_ff     <= ST_IDLE;
         wheel_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_distance_ff   <= step_distance_in;
         speed_numerator_ff <= speed_numerator_in;
         speed_limit_ff     <= speed_limit_in;
         filter_weight_ff   <= filter_weight_in;
         last_capture_ff    <= last_capture_in;
         edge_period_ff     <= edge_period_in;
         moved_mark_ff      <= moved_mark_in;
         wheel_distance_ff  <= wheel_distance_in;
         wheel_speed_ff     <= wheel_speed_in;
         state_ff           <= state_in;
         wheel_ff           <= wheel_in;
         cnt_ff             <= cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // datapath and result payload, no reset needed
   always_ff @(posedge clock) begin
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      raw_ff       <= raw_in;
      prod_ff      <= prod_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_speed    = rsp_left_ff;
   assign rsp_right_speed   = rsp_right_ff;
   assign rsp_mean_speed    = rsp_mean_ff;
   assign rsp_mean_distance = rsp_dist_ff;

   // a tick transaction always starts the divider
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_TICK) |=> (state_ff == ST_DIV))
      else $error("tick transaction did not start the divider");

   // remainder stays below the divisor once the division finishes
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (rem_ff < div_ext))
      else $error("divider remainder not below divisor");

   // both moved marks are clear once a tick has been filtered
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && $past(state_ff == ST_FILT)) |->
      (moved_mark_ff[0] == MARK_NONE && moved_mark_ff[1] == MARK_NONE))
      else $error("moved marks not cleared after tick");

   // a new result only comes out of the completion state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion state");

endmodule

// ===== tb/sv/wheel_odometry_checker.sv =====
// checker that predicts and compares every speed and distance reading of the estimator
`timescale 1ns / 1ps

module wheel_odometry_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_op,
   input  logic                          req_wheel,
   input  logic [15:0]                   req_capture_value,
   input  logic                          req_forward,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [15:0]            rsp_left_speed,
   input  logic signed [15:0]            rsp_right_speed,
   input  logic signed [15:0]            rsp_mean_speed,
   input  logic signed [31:0]            rsp_mean_distance,
   input  logic                          csr_wr_en,
   input  logic [wse_pkg::CSR_BITS-1:0]  csr_index,
   input  logic [wse_pkg::DATA_BITS-1:0] csr_wdata,
   output int                            outstanding,
   output int                            mismatches,
   output int                            readings_checked
);
   import wse_pkg::*;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [15:0] mean_speed;
      logic signed [31:0] mean_distance;
   } odometry_reading_type;

   logic [15:0]        step_dist;
   logic [31:0]        numer;
   logic [14:0]        limit;
   logic [8:0]         weight;

   logic [15:0]        last_stamp [2];
   logic [16:0]        period     [2];
   mark_type           mark       [2];
   logic [31:0]        wheel_dist [2];
   logic signed [15:0] speed      [2];

   odometry_reading_type expected_readings [$];

   function automatic logic signed [15:0] raw_speed_of(int k);
      logic [16:0] p;
      logic [31:0] q;
      // a zero period stands for a full timer wrap
      p = (period[k] == 17'd0) ? 17'h10000 : period[k];
      q = numer / {15'd0, p};
      if (mark[k] == MARK_NONE)
         return 16'sd0;
      if (mark[k] == MARK_FWD)
         return (q > SPEED_POS_MAX) ? 16'h7FFF : q[15:0];
      return (q > SPEED_NEG_MAG) ? 16'h8000 : 16'd0 - q[15:0];
   endfunction

   function automatic logic signed [15:0] smoothed(logic signed [15:0] raw,
                                                   logic signed [15:0] prev);
      longint w;
      longint acc;
      w   = (weight > FILTER_WEIGHT_MAX) ? FILTER_WEIGHT_MAX : weight;
      acc = longint'(raw) * (256 - w) + longint'(prev) * w;
      return 16'(acc >>> 8);
   endfunction

   function automatic void record_edge(logic k, logic [15:0] cap, logic fwd);
      logic [15:0] d;
      d = cap - last_stamp[k];
      period[k]     = (d == 16'd0) ? 17'h10000 : {1'b0, d};
      last_stamp[k] = cap;
      if (fwd) begin
         mark[k]       = MARK_FWD;
         wheel_dist[k] = wheel_dist[k] + {16'd0, step_dist};
      end else begin
         mark[k]       = MARK_REV;
         wheel_dist[k] = wheel_dist[k] - {16'd0, step_dist};
      end
   endfunction

   function automatic void sample_speeds();
      logic signed [15:0] raw;
      logic [15:0]        mag;
      for (int k = 0; k < 2; k++) begin
         raw = raw_speed_of(k);
         mag = raw[15] ? 16'(-raw) : raw;
         // implausible speed: hold the previous filtered value
         if (mag > {1'b0, limit})
            raw = speed[k];
         speed[k] = smoothed(raw, speed[k]);
         mark[k]  = MARK_NONE;
      end
   endfunction

   function automatic odometry_reading_type current_reading();
      odometry_reading_type r;
      logic signed [16:0]   ssum;
      logic signed [32:0]   dsum;
      ssum = speed[0] + speed[1];
      dsum = $signed(wheel_dist[0]) + $signed(wheel_dist[1]);
      r.left_speed    = speed[0];
      r.right_speed   = speed[1];
      r.mean_speed    = 16'(ssum >>> 1);
      r.mean_distance = 32'(dsum >>> 1);
      return r;
   endfunction

   task automatic check_reading(input odometry_reading_type want);
      if (rsp_left_speed !== want.left_speed) begin
         $error("left_speed expected %0d got %0d", want.left_speed, rsp_left_speed);
         mismatches++;
      end
      if (rsp_right_speed !== want.right_speed) begin
         $error("right_speed expected %0d got %0d", want.right_speed, rsp_right_speed);
         mismatches++;
      end
      if (rsp_mean_speed !== want.mean_speed) begin
         $error("mean_speed expected %0d got %0d", want.mean_speed, rsp_mean_speed);
         mismatches++;
      end
      if (rsp_mean_distance !== want.mean_distance) begin
         $error("mean_distance expected %0d got %0d", want.mean_distance,
                rsp_mean_distance);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         step_dist = STEP_DISTANCE_RST;
         numer     = SPEED_NUMERATOR_RST;
         limit     = SPEED_LIMIT_RST;
         weight    = FILTER_WEIGHT_RST;
         for (int k = 0; k < 2; k++) begin
            last_stamp[k] = '0;
            period[k]     = '0;
            mark[k]       = MARK_NONE;
            wheel_dist[k] = '0;
            speed[k]      = '0;
         end
         expected_readings.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STEP_DISTANCE:   step_dist = csr_wdata[15:0];
               CSR_SPEED_NUMERATOR: numer     = csr_wdata[31:0];
               CSR_SPEED_LIMIT:     limit     = csr_wdata[14:0];
               CSR_FILTER_WEIGHT:   weight    = csr_wdata[8:0];
               default: ;
            endcase
         end
         // results first, so a stray one is not hidden by a same-edge transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("reading arrived with none expected");
               mismatches++;
            end else begin
               check_reading(expected_readings.pop_front());
               readings_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_TICK)
               sample_speeds();
            else
               record_edge(req_wheel, req_capture_value, req_forward);
            expected_readings.push_back(current_reading());
         end
      end
      outstanding <= expected_readings.size();
   end

endmodule

// ===== tb/sv/wheel_encoder_speed_estimator_top_test.sv =====
// testbench top: stimulus, register settings and verdict for the speed estimator
`timescale 1ns / 1ps

module wheel_encoder_speed_estimator_top_test;
   import wse_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 400;
   localparam int RANDOM_PHASES = 5;
   localparam int TAIL_CYCLES   = 100;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_op;
   logic                  req_wheel;
   logic [15:0]           req_capture_value;
   logic                  req_forward;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [15:0]    rsp_left_speed;
   logic signed [15:0]    rsp_right_speed;
   logic signed [15:0]    rsp_mean_speed;
   logic signed [31:0]    rsp_mean_distance;
   logic                  csr_wr_en;
   logic [CSR_BITS-1:0]   csr_index;
   logic [DATA_BITS-1:0]  csr_wdata;

   int   outstanding;
   int   mismatches;
   int   readings_checked;
   bit   idling = 1'b1;
   logic [15:0] stamp   [2];
   logic        heading [2];
   int   captures;
   int   ticks;
   int   settings;

   wheel_encoder_speed_estimator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_wheel         (req_wheel),
      .req_capture_value (req_capture_value),
      .req_forward       (req_forward),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_mean_speed    (rsp_mean_speed),
      .rsp_mean_distance (rsp_mean_distance),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   wheel_odometry_checker reading_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_wheel         (req_wheel),
      .req_capture_value (req_capture_value),
      .req_forward       (req_forward),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_mean_speed    (rsp_mean_speed),
      .rsp_mean_distance (rsp_mean_distance),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .outstanding       (outstanding),
      .mismatches        (mismatches),
      .readings_checked  (readings_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_item(input logic op, input logic wheel, input logic [15:0] cap,
                            input logic fwd);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_wheel         <= wheel;
      req_capture_value <= cap;
      req_forward       <= fwd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_TICK) begin
         ticks++;
      end else begin
         captures++;
         stamp[wheel] = cap;
      end
   endtask

   // called on the edge of the last transaction; returns once every reading is in
   task automatic await_readings();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic program_regs(input logic [15:0] step, input logic [31:0] numer,
                               input logic [14:0] limit, input logic [8:0] weight,
                               input bit junk);
      logic [31:0] noise;
      // bits above a register's width must be dropped
      noise = junk ? $urandom() : 32'd0;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_STEP_DISTANCE;
      csr_wdata <= {noise[31:16], step};
      @(posedge clock);
      csr_index <= CSR_SPEED_NUMERATOR;
      csr_wdata <= numer;
      @(posedge clock);
      csr_index <= CSR_SPEED_LIMIT;
      csr_wdata <= {noise[31:15], limit};
      @(posedge clock);
      csr_index <= CSR_FILTER_WEIGHT;
      csr_wdata <= {noise[31:9], weight};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   task automatic program_random_settings();
      logic [15:0] step;
      logic [31:0] numer;
      logic [14:0] limit;
      logic [8:0]  weight;
      case ($urandom_range(0, 3))
         0:       step = 16'd1;
         1:       step = 16'hFFFF;
         default: step = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 5))
         0:       numer = 32'd0;
         1:       numer = 32'hFFFF_FFFF;
         2:       numer = $urandom();
         default: numer = 32'($urandom_range(1024, 32767)) << $urandom_range(0, 10);
      endcase
      case ($urandom_range(0, 5))
         0:       limit = 15'd0;
         1:       limit = 15'h7FFF;
         2:       limit = SPEED_LIMIT_RST;
         default: limit = 15'($urandom());
      endcase
      case ($urandom_range(0, 3))
         0:       weight = 9'd0;
         1:       weight = FILTER_WEIGHT_MAX;
         default: weight = 9'($urandom_range(0, 256));
      endcase
      program_regs(step, numer, limit, weight, 1'($urandom_range(0, 1)));
   endtask

   // mostly short periods on a log scale, with the odd full timer wrap
   function automatic logic [16:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 17'($urandom_range(1, 4));
         1:       return 17'h10000;
         2:       return 17'($urandom_range(1, 65536));
         default: return 17'($urandom_range(1, 1 << $urandom_range(1, 16)));
      endcase
   endfunction

   task automatic random_item();
      int   r;
      logic k;
      r = $urandom_range(0, 99);
      k = 1'($urandom_range(0, 1));
      if (r < 25) begin
         send_item(OP_TICK, k, 16'($urandom()), 1'($urandom_range(0, 1)));
      end else if (r < 88) begin
         if ($urandom_range(0, 19) == 0)
            heading[k] = ~heading[k];
         send_item(OP_CAPTURE, k, stamp[k] + 16'(pick_period()), heading[k]);
      end else begin
         send_item(OP_CAPTURE, k, 16'($urandom()), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : rsp_backpressure
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_op            <= OP_CAPTURE;
      req_wheel         <= 1'b0;
      req_capture_value <= '0;
      req_forward       <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_STEP_DISTANCE;
      csr_wdata         <= '0;
      stamp[0]   = '0;
      stamp[1]   = '0;
      heading[0] = 1'b1;
      heading[1] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // default registers, no edges seen yet
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      // capture equal to the stored one counts as a full timer wrap
      send_item(OP_CAPTURE, 1'b0, 16'h0000, 1'b1);
      send_item(OP_CAPTURE, 1'b1, 16'hFFFF, 1'b0);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      // short forward period within the limit, reverse period across the wrap beyond it
      send_item(OP_CAPTURE, 1'b0, 16'h0004, 1'b1);
      send_item(OP_CAPTURE, 1'b1, 16'h0001, 1'b0);
      send_item(OP_TICK, 1'b1, 16'hFFFF, 1'b1);
      // period of one saturates the forward speed
      send_item(OP_CAPTURE, 1'b0, 16'h0005, 1'b1);
      send_item(OP_CAPTURE, 1'b1, 16'h0101, 1'b1);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      // no edges since the last tick: speeds decay
      send_item(OP_TICK, 1'b1, 16'h5A5A, 1'b1);
      // successive captures on one wheel before a tick, the later one counts
      send_item(OP_CAPTURE, 1'b1, 16'h0101, 1'b0);
      send_item(OP_CAPTURE, 1'b1, 16'h8101, 1'b0);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      await_readings();

      program_regs(16'hFFFF, 32'hFFFF_FFFF, 15'h7FFF, 9'd0, 1'b0);
      send_item(OP_CAPTURE, 1'b0, 16'h0006, 1'b1);
      send_item(OP_CAPTURE, 1'b1, 16'h8102, 1'b0);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      send_item(OP_CAPTURE, 1'b1, 16'h8102, 1'b1);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);
      await_readings();

      program_regs(16'd1, 32'd0, 15'd0, FILTER_WEIGHT_MAX, 1'b1);
      send_item(OP_CAPTURE, 1'b0, 16'h0007, 1'b0);
      send_item(OP_CAPTURE, 1'b1, 16'h8103, 1'b1);
      send_item(OP_TICK, 1'b0, 16'h0000, 1'b0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         await_readings();
         program_random_settings();
         idling = (phase < RANDOM_PHASES - 1);
         repeat (PHASE_ITEMS) begin
            random_item();
            if ($urandom_range(0, 199) == 0)
               await_readings();
         end
      end

      await_readings();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d capture and %0d tick transactions under %0d register settings",
               captures, ticks, settings + 1);
      $display("%0d readings compared, %0d field mismatches", readings_checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
